// ----- rtl/fcs_pkg.sv -----
// Shared constants and types for the corner score unit.
`timescale 1ns / 1ps
package fcs_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_ARC    = 12;
  localparam int RING_N     = 16;
  localparam int WIN_N      = 7;
  localparam int LINES      = 6;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int EFFW_W = COL_W + 1;
  localparam int EFFH_W = ROW_W + 1;
  localparam int LEAD_W = 13;
  localparam int SCORE_W = 5;

  localparam logic [7:0] THRESHOLD_RST = 8'd20;
  localparam logic [10:0] WIDTH_RST    = 11'd640;
  localparam logic [12:0] HEIGHT_RST   = 13'd480;

  // Circle pixels as window row and column, clockwise from the top.
  localparam int RING_R [RING_N] = '{0, 0, 1, 2, 3, 4, 5, 6, 6, 6, 5, 4, 3, 2, 1, 0};
  localparam int RING_C [RING_N] = '{3, 4, 5, 6, 6, 6, 5, 4, 3, 2, 1, 0, 0, 0, 1, 2};

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_WIDTH     = 2'd1,
    REG_HEIGHT    = 2'd2
  } reg_index_t;

  typedef logic [RING_N-1:0][7:0] ring_t;
  typedef logic [SCORE_W-1:0] score_t;

endpackage

// ----- rtl/fcs_seg.sv -----
// Segment test: registered dark/bright compares, then longest qualifying arc.
`timescale 1ns / 1ps
module fcs_seg (
  input  logic               clk,
  input  logic               load,
  input  fcs_pkg::ring_t     ring,
  input  logic [7:0]         centre,
  input  logic [7:0]         threshold,
  output fcs_pkg::score_t    score
);

  logic [fcs_pkg::RING_N-1:0] dark_strict;
  logic [fcs_pkg::RING_N-1:0] dark_loose;
  logic [fcs_pkg::RING_N-1:0] bright_strict;
  logic [fcs_pkg::RING_N-1:0] bright_loose;

  // lo = centre - thr, hi = centre + thr, compared without going negative
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < fcs_pkg::RING_N; i++) begin
        dark_strict[i]   <= ({1'b0, ring[i]} + {1'b0, threshold}) < {1'b0, centre};
        dark_loose[i]    <= ({1'b0, ring[i]} + {1'b0, threshold}) <= {1'b0, centre};
        bright_strict[i] <= {1'b0, ring[i]} > ({1'b0, centre} + {1'b0, threshold});
        bright_loose[i]  <= {1'b0, ring[i]} >= ({1'b0, centre} + {1'b0, threshold});
      end
    end
  end

  always_comb begin
    logic hit;
    logic ok_d;
    logic ok_b;
    score = '0;
    for (int len = fcs_pkg::MIN_ARC; len <= fcs_pkg::RING_N; len++) begin
      hit = 1'b0;
      for (int i = 0; i < fcs_pkg::RING_N; i++) begin
        ok_d = dark_strict[i];
        ok_b = bright_strict[i];
        for (int j = 1; j < len; j++) begin
          ok_d = ok_d & dark_loose[4'(i + j)];
          ok_b = ok_b & bright_loose[4'(i + j)];
        end
        hit = hit | ok_d | ok_b;
      end
      if (hit) score = fcs_pkg::SCORE_W'(len);
    end
  end

endmodule

// ----- rtl/fast_corner_score_unit.sv -----
// Top level of the streaming corner score unit.
`timescale 1ns / 1ps
// Usage:
//   Pixels enter on the s_ channel in raster order: s_tdata[7:0] is the pixel,
//   s_tuser is the flush flag (no pixel, drains one pending score).
//   Scores leave on the m_ channel: m_tdata[4:0] is the score (0 or 12..16),
//   m_tlast marks the frame's final pixel.
//   The APB port sets threshold (0x0), image width (0x4) and image height (0x8).
//   Scores trail the input by 3 rows plus 3 pixels: the first 3*W+3 pixels of
//   a stream fill the line stores and yield nothing; each later pixel yields
//   one score. Send 3*W+3 flush requests after a frame to drain its tail.
//   One request is taken per clock. A score shows on the m_ channel once the
//   request that releases it has passed four registers (line store read,
//   window, compare, output register), the first loaded at the accepting
//   edge.
//   When the receiver stalls the pipeline keeps taking requests until its
//   stages are full, then holds s_tready low; nothing is dropped.
//   Reset clears position counters, the window and the pending count and
//   restores the register defaults; the line stores need no clearing, rows not
//   yet written in the current frame are masked to zero.
module fast_corner_score_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] pixel_value
  input  logic        s_tuser,   // [0] flush
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [4:0] corner_score, [7:5] zero
  output logic        m_tlast,   // frame_last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = fcs_pkg::COL_W;
  localparam int RW = fcs_pkg::ROW_W;
  localparam int EW = fcs_pkg::EFFW_W;
  localparam int EH = fcs_pkg::EFFH_W;
  localparam int LW = fcs_pkg::LEAD_W;
  localparam int NL = fcs_pkg::LINES;

  // Configuration registers
  logic [7:0]  threshold;
  logic [10:0] image_width;
  logic [12:0] image_height;
  logic        cfg_write;
  fcs_pkg::reg_index_t cfg_sel;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_sel   = fcs_pkg::reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= fcs_pkg::THRESHOLD_RST;
      image_width  <= fcs_pkg::WIDTH_RST;
      image_height <= fcs_pkg::HEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_sel)
        fcs_pkg::REG_THRESHOLD: threshold    <= pwdata[7:0];
        fcs_pkg::REG_WIDTH:     image_width  <= pwdata[10:0];
        fcs_pkg::REG_HEIGHT:    image_height <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      fcs_pkg::REG_THRESHOLD: prdata = {24'd0, threshold};
      fcs_pkg::REG_WIDTH:     prdata = {21'd0, image_width};
      fcs_pkg::REG_HEIGHT:    prdata = {19'd0, image_height};
      default:                prdata = '0;
    endcase
  end

  // Effective frame size
  logic [EW-1:0] eff_w;
  logic [EH-1:0] eff_h;
  logic [11:0]   limit;

  always_comb begin
    if (image_width == '0) eff_w = EW'(1);
    else if (image_width > 11'(fcs_pkg::MAX_WIDTH)) eff_w = EW'(fcs_pkg::MAX_WIDTH);
    else eff_w = EW'(image_width);
    if (image_height == '0) eff_h = EH'(1);
    else if (image_height > 13'(fcs_pkg::MAX_HEIGHT)) eff_h = EH'(fcs_pkg::MAX_HEIGHT);
    else eff_h = EH'(image_height);
    limit = 12'(12'(eff_w) * 12'd3 + 12'd3);
  end

  // Pipeline handshake
  logic s1_v, s2_v, s3_v;
  logic en1, en2, en3;
  logic accept;

  assign en3      = !m_tvalid || m_tready;
  assign en2      = !s3_v || en3;
  assign en1      = !s2_v || en2;
  assign s_tready = !s1_v || en1;
  assign accept   = s_tvalid && s_tready;

  // Position and pending counters, advanced per request
  logic [CW-1:0] in_column, out_column;
  logic [RW-1:0] in_row, out_row;
  logic [LW-1:0] lead_count;
  logic          push, emit, inner, last_pix;

  always_comb begin
    push  = !s_tuser;
    emit  = s_tuser ? (lead_count != '0) : (lead_count >= LW'(limit));
    inner = (out_row >= RW'(3)) && ((EH'(out_row) + EH'(3)) < eff_h) &&
            (out_column >= CW'(3)) && ((EW'(out_column) + EW'(3)) < eff_w);
    last_pix = ((EH'(out_row) + EH'(1)) >= eff_h) && ((EW'(out_column) + EW'(1)) >= eff_w);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
      lead_count <= '0;
    end else if (accept) begin
      if (push) begin
        if ((EW'(in_column) + EW'(1)) >= eff_w) begin
          in_column <= '0;
          in_row    <= ((EH'(in_row) + EH'(1)) >= eff_h) ? '0 : in_row + RW'(1);
        end else begin
          in_column <= in_column + CW'(1);
        end
        if (!emit) lead_count <= lead_count + LW'(1);
      end else if (emit) begin
        lead_count <= lead_count - LW'(1);
      end
      if (emit) begin
        if ((EW'(out_column) + EW'(1)) >= eff_w) begin
          out_column <= '0;
          out_row    <= ((EH'(out_row) + EH'(1)) >= eff_h) ? '0 : out_row + RW'(1);
        end else begin
          out_column <= out_column + CW'(1);
        end
      end
    end
  end

  // Stage 1: request plus line store read
  logic [7:0]      s1_pix;
  logic            s1_push, s1_emit, s1_use, s1_last;
  logic [CW-1:0]   s1_col;
  logic [NL-1:0]   s1_gate;
  logic [NL*8-1:0] rd_data, fwd_data, wr_data, raw;
  logic            fwd_hit;
  logic [NL*8-1:0] line_mem [fcs_pkg::MAX_WIDTH];
  logic [7:0]      col [fcs_pkg::WIN_N];
  logic            wr_en;

  assign wr_en = s1_v && en1 && s1_push;
  assign raw   = fwd_hit ? fwd_data : rd_data;

  always_comb begin
    for (int k = 0; k < NL; k++) begin
      col[k] = s1_gate[k] ? raw[k*8 +: 8] : 8'd0;
    end
    col[NL] = s1_pix;
    for (int k = 0; k < NL; k++) begin
      wr_data[k*8 +: 8] = col[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) line_mem[s1_col] <= wr_data;
    if (accept) rd_data <= line_mem[in_column];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v    <= 1'b0;
      fwd_hit <= 1'b0;
    end else begin
      if (accept) begin
        s1_v    <= 1'b1;
        // same column written this edge: memory still returns the old word
        fwd_hit <= wr_en && (s1_col == in_column);
      end else if (en1) begin
        s1_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix   <= s_tdata;
      s1_push  <= push;
      s1_emit  <= emit;
      s1_use   <= push && inner;
      s1_last  <= last_pix;
      s1_col   <= in_column;
      fwd_data <= wr_data;
      for (int k = 0; k < NL; k++) begin
        s1_gate[k] <= in_row >= RW'(NL - k);
      end
    end
  end

  // Window shifts as a pixel (not a flush) moves on from stage 1
  logic [7:0] win [fcs_pkg::WIN_N][fcs_pkg::WIN_N];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < fcs_pkg::WIN_N; r++) begin
        for (int c = 0; c < fcs_pkg::WIN_N; c++) begin
          win[r][c] <= 8'd0;
        end
      end
    end else if (wr_en) begin
      for (int r = 0; r < fcs_pkg::WIN_N; r++) begin
        for (int c = 0; c < fcs_pkg::WIN_N - 1; c++) begin
          win[r][c] <= win[r][c+1];
        end
        win[r][fcs_pkg::WIN_N-1] <= col[r];
      end
    end
  end

  // Stage 2: compares on the current window
  logic s2_emit, s2_use, s2_last;
  logic s3_emit, s3_use, s3_last;
  fcs_pkg::ring_t  ring;
  fcs_pkg::score_t seg_score;

  always_comb begin
    for (int i = 0; i < fcs_pkg::RING_N; i++) begin
      ring[i] = win[fcs_pkg::RING_R[i]][fcs_pkg::RING_C[i]];
    end
  end

  fcs_seg u_seg (
    .clk       (clk),
    .load      (s2_v && en2),
    .ring      (ring),
    .centre    (win[3][3]),
    .threshold (threshold),
    .score     (seg_score)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v     <= 1'b0;
      s3_v     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (en1) s2_v <= s1_v;
      if (en2) s3_v <= s2_v;
      if (en3) m_tvalid <= s3_v && s3_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s2_emit <= s1_emit;
      s2_use  <= s1_use;
      s2_last <= s1_last;
    end
    if (en2) begin
      s3_emit <= s2_emit;
      s3_use  <= s2_use;
      s3_last <= s2_last;
    end
    if (en3) begin
      m_tdata <= {3'd0, s3_use ? seg_score : fcs_pkg::score_t'(0)};
      m_tlast <= s3_last;
    end
  end

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the streaming corner score unit.
`timescale 1ns / 1ps
module testbench;

  typedef struct {
    logic [4:0] score;
    logic       last;
  } score_item_t;

  localparam int HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // [7:0] pixel_value
  logic        s_tuser = 1'b0;   // [0] flush
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;          // [4:0] corner_score, [7:5] zero
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  fast_corner_score_unit uut (.*);

  always #5 clk = ~clk;

  // Scorer state mirrored on the testbench side.
  logic [7:0]  line_mem [fcs_pkg::LINES][fcs_pkg::MAX_WIDTH];
  logic [7:0]  win [fcs_pkg::WIN_N][fcs_pkg::WIN_N];
  int          thr_reg, width_reg, height_reg;
  int          in_col, in_row, out_col, out_row, lead;
  score_item_t pending_scores[$];

  int  tx_gap_max = 0;
  int  rx_stall_max = 0;
  bit  hold_req = 0;
  int  errors = 0;
  int  items_sent = 0;
  int  scores_seen = 0;
  int  corners_seen = 0;
  int  frames_sent = 0;

  function automatic int eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > fcs_pkg::MAX_WIDTH) return fcs_pkg::MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int eff_height();
    if (height_reg == 0) return 1;
    if (height_reg > fcs_pkg::MAX_HEIGHT) return fcs_pkg::MAX_HEIGHT;
    return height_reg;
  endfunction

  function automatic int arc_length();
    int ring [fcs_pkg::RING_N];
    int lo, hi, best, run, v;
    bit dark;
    lo = int'(win[3][3]) - thr_reg;
    hi = int'(win[3][3]) + thr_reg;
    best = 0;
    for (int i = 0; i < fcs_pkg::RING_N; i++)
      ring[i] = win[fcs_pkg::RING_R[i]][fcs_pkg::RING_C[i]];
    for (int i = 0; i < fcs_pkg::RING_N; i++) begin
      if (ring[i] < lo) dark = 1;
      else if (ring[i] > hi) dark = 0;
      else continue;
      run = 1;
      for (int j = 1; j < fcs_pkg::RING_N; j++) begin
        v = ring[(i + j) % fcs_pkg::RING_N];
        if (dark ? (v > lo) : (v < hi)) break;
        run++;
      end
      if (run > best) best = run;
    end
    return (best >= fcs_pkg::MIN_ARC) ? best : 0;
  endfunction

  task automatic shift_in(input logic [7:0] pix);
    logic [7:0] col [fcs_pkg::WIN_N];
    int c;
    c = (in_col >= fcs_pkg::MAX_WIDTH) ? fcs_pkg::MAX_WIDTH - 1 : in_col;
    // Mask rows not yet written in this frame.
    for (int k = 0; k < fcs_pkg::LINES; k++)
      col[k] = (in_row >= fcs_pkg::LINES - k) ? line_mem[k][c] : 8'd0;
    col[fcs_pkg::LINES] = pix;
    for (int k = 0; k < fcs_pkg::LINES; k++) line_mem[k][c] = col[k + 1];
    for (int r = 0; r < fcs_pkg::WIN_N; r++) begin
      for (int q = 0; q < fcs_pkg::WIN_N - 1; q++) win[r][q] = win[r][q + 1];
      win[r][fcs_pkg::WIN_N - 1] = col[r];
    end
    if (in_col + 1 >= eff_width()) begin
      in_col = 0;
      in_row = (in_row + 1 >= eff_height()) ? 0 : in_row + 1;
    end else begin
      in_col++;
    end
  endtask

  task automatic queue_score(input bit use_win);
    score_item_t s;
    int w, h;
    w = eff_width();
    h = eff_height();
    s.score = 5'd0;
    if (use_win && out_row >= 3 && out_row + 3 < h && out_col >= 3 && out_col + 3 < w)
      s.score = 5'(arc_length());
    s.last = (out_row + 1 >= h && out_col + 1 >= w);
    pending_scores.push_back(s);
    if (out_col + 1 >= w) begin
      out_col = 0;
      out_row = (out_row + 1 >= h) ? 0 : out_row + 1;
    end else begin
      out_col++;
    end
  endtask

  task automatic predict_item(input logic [7:0] pix, input logic fl);
    if (fl) begin
      if (lead > 0) begin
        lead--;
        queue_score(0);
      end
    end else begin
      shift_in(pix);
      if (lead < 3 * eff_width() + 3) lead++;
      else queue_score(1);
    end
  endtask

  task automatic send_item(input logic [7:0] pix, input logic fl);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    s_tuser  <= fl;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    predict_item(pix, fl);
  endtask

  // Wait until every score is out, then let the pipeline settle.
  task automatic drain_wait();
    s_tvalid <= 1'b0;
    while (pending_scores.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input fcs_pkg::reg_index_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(idx) << 2;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      fcs_pkg::REG_THRESHOLD: thr_reg = val[7:0];
      fcs_pkg::REG_WIDTH:     width_reg = val[10:0];
      fcs_pkg::REG_HEIGHT:    height_reg = val[12:0];
      default: ;
    endcase
  endtask

  // One frame from a chosen content style, then drain the tail.
  task automatic send_frame(input int w, input int h, input int thr, input int style,
                            input bit noise);
    int ew, eh, bg, fg, r0, c0, sz, extra;
    logic [7:0] p;
    drain_wait();
    write_reg(fcs_pkg::REG_THRESHOLD, thr);
    write_reg(fcs_pkg::REG_WIDTH, w);
    write_reg(fcs_pkg::REG_HEIGHT, h);
    ew = eff_width();
    eh = eff_height();
    bg = $urandom_range(0, 255);
    fg = $urandom_range(0, 255);
    sz = $urandom_range(1, 4);
    r0 = $urandom_range(0, eh);
    c0 = $urandom_range(0, ew);
    for (int r = 0; r < eh; r++) begin
      for (int c = 0; c < ew; c++) begin
        if (noise && $urandom_range(0, 39) == 0) send_item(8'($urandom), 1'b1);
        case (style)
          0: p = 8'($urandom);
          1: p = ($urandom_range(0, 2) == 0) ? 8'd0 : ($urandom_range(0, 1) ? 8'd128 : 8'd255);
          2: p = ($urandom_range(0, 9) == 0) ? 8'(fg) : 8'(bg);
          default: begin
            p = (r >= r0 && r < r0 + sz && c >= c0 && c < c0 + sz) ? 8'(fg) : 8'(bg);
            if ($urandom_range(0, 15) == 0) p = 8'($urandom);
          end
        endcase
        send_item(p, 1'b0);
      end
    end
    while (lead > 0) send_item(8'($urandom), 1'b1);
    // Flush requests with nothing pending produce no score.
    extra = $urandom_range(0, 2);
    repeat (extra) send_item(8'($urandom), 1'b1);
    frames_sent++;
  endtask

  task automatic test_directed();
    tx_gap_max = 2;
    rx_stall_max = 2;
    // Reset defaults apply until the first write: two flushes on an empty pipe.
    send_item(8'hFF, 1'b1);
    send_item(8'h00, 1'b1);
    drain_wait();
    write_reg(fcs_pkg::REG_THRESHOLD, 0);
    write_reg(fcs_pkg::REG_WIDTH, 1);
    write_reg(fcs_pkg::REG_HEIGHT, 1);
    // Fill the six-deep lead with a single-pixel frame, then release.
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hAA, 1'b0);
    send_item(8'h55, 1'b0);
    send_item(8'h0F, 1'b0);
    send_item(8'hF0, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'h7F, 1'b1);
    while (lead > 0) send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b1);
  endtask

  task automatic test_spot_frames();
    tx_gap_max = 4;
    rx_stall_max = 4;
    send_frame(7, 7, 0, 2, 0);
    send_frame(9, 8, 255, 2, 0);
    send_frame(10, 9, 1, 3, 0);
  endtask

  task automatic test_size_extremes();
    tx_gap_max = 0;
    rx_stall_max = 1;
    send_frame(0, 12, 20, 1, 0);
    send_frame(8, 0, 20, 2, 0);
    send_frame(1, 9, 5, 0, 0);
    send_frame(24, 5, 40, 2, 0);
  endtask

  task automatic test_backpressure();
    tx_gap_max = 0;
    rx_stall_max = 0;
    drain_wait();
    hold_req = 1;
    send_frame(12, 10, 15, 2, 0);
    send_frame(8, 8, 25, 3, 1);
  endtask

  task automatic test_random_frames();
    int start, thr, pick;
    start = items_sent;
    while (items_sent - start < 450) begin
      pick = $urandom_range(0, 9);
      thr = (pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(0, 80);
      case ($urandom_range(0, 3))
        0: begin tx_gap_max = 0; rx_stall_max = 0; end
        1: begin tx_gap_max = 18; rx_stall_max = 0; end
        2: begin tx_gap_max = 0; rx_stall_max = 18; end
        default: begin tx_gap_max = 18; rx_stall_max = 18; end
      endcase
      send_frame($urandom_range(7, 14), $urandom_range(7, 12), thr,
                 $urandom_range(0, 3), $urandom_range(0, 3) == 0);
    end
  endtask

  // Score receiver and checker.
  initial begin
    score_item_t want;
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end
      stall = $urandom_range(0, rx_stall_max);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      scores_seen++;
      if (pending_scores.size() == 0) begin
        errors++;
        $display("%0t: unexpected score, expected none, actual score %0d last %0b",
                 $time, m_tdata[4:0], m_tlast);
      end else begin
        want = pending_scores.pop_front();
        if (want.score != 0) corners_seen++;
        if (m_tdata[4:0] !== want.score) begin
          errors++;
          $display("%0t: corner_score expected %0d actual %0d", $time, want.score,
                   m_tdata[4:0]);
        end
        if (m_tlast !== want.last) begin
          errors++;
          $display("%0t: frame_last expected %0b actual %0b", $time, want.last, m_tlast);
        end
      end
    end
  end

  initial begin
    #50ms;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    thr_reg = fcs_pkg::THRESHOLD_RST;
    width_reg = fcs_pkg::WIDTH_RST;
    height_reg = fcs_pkg::HEIGHT_RST;
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
    lead = 0;
    for (int k = 0; k < fcs_pkg::LINES; k++)
      for (int c = 0; c < fcs_pkg::MAX_WIDTH; c++) line_mem[k][c] = 8'd0;
    for (int r = 0; r < fcs_pkg::WIN_N; r++)
      for (int c = 0; c < fcs_pkg::WIN_N; c++) win[r][c] = 8'd0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_spot_frames();
    test_size_extremes();
    test_backpressure();
    test_random_frames();
    drain_wait();
    repeat (20) @(posedge clk);
    if (pending_scores.size() != 0) begin
      errors++;
      $display("%0t: %0d scores never arrived", $time, pending_scores.size());
    end
    $display("Covered %0d requests over %0d frames; %0d scores checked, %0d nonzero.",
             items_sent, frames_sent, scores_seen, corners_seen);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
